FILE: sv/mtq_pkg.sv
// package: shared types, constants and state codes for the timer event queue
package mtq_pkg;

   localparam int MAX_TIMERS_DEF  = 16;
   localparam int EVENT_DEPTH_DEF = 16;
   localparam logic [15:0] SCALE_RESET = 16'd256;
   localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_ADD   = 2'd1,
      OP_POLL  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] delta_us;
      logic [31:0] timer_period;
      logic [7:0]  timer_id;
   } req_type;

   typedef struct packed {
      logic        event_valid;
      logic [7:0]  event_id;
      logic [47:0] real_time;
      logic [47:0] virtual_time;
      logic [31:0] real_delta;
      logic        timer_rejected;
      logic        events_dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_RD,
      ST_DIV,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch request, start op
      logic exec;      // perform add/poll/clear/tick clock update
      logic scan_init; // reset scan index
      logic scan_rd;   // read table entry at scan index
      logic div_start; // start divider
      logic update;    // apply firing decision, advance index
      logic respond;   // drive response strobe
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic scan_more;
      logic div_done;
   } sts_type;

endpackage

FILE: sv/multi_timer_event_queue_core.sv
// top level: periodic timer table with event queue, command-style interface
//
// channel   ports                      handshake
// request   start, busy, req_data      start & !busy
// response  rsp_valid, rsp_data        one-cycle strobe, no back-pressure
// config    csr_valid, csr_ready, csr_data   valid & ready
//
// add, poll and clear pass from start through the exec and done states to rsp_valid.
// a tick also reads and divides every timer in use: the 48-step
// serial divider per table entry dominates.
// synchronous reset; time_scale resets to 1.0; tables need no clearing.
// csr_ready is high only while the block is idle.
module multi_timer_event_queue_core #(
   parameter int MAX_TIMERS  = mtq_pkg::MAX_TIMERS_DEF,
   parameter int EVENT_DEPTH = mtq_pkg::EVENT_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mtq_pkg::req_type req_data,
   output logic             rsp_valid,
   output mtq_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import mtq_pkg::*;

   ctl_type     ctl;
   sts_type     sts;
   logic        idle;
   logic [15:0] scale_ff;

   // time scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_data;
      end
   end

   assign csr_ready = idle;
   assign rsp_valid = ctl.respond;

   mtq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy),
      .idle  (idle)
   );

   mtq_datapath #(
      .MAX_TIMERS  (MAX_TIMERS),
      .EVENT_DEPTH (EVENT_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req        (req_data),
      .time_scale (scale_ff),
      .rsp_data   (rsp_data)
   );
endmodule

FILE: sv/mtq_div.sv
// module: restoring divider, 48 by 32 bit, one quotient bit per cycle
module mtq_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [47:0] quotient,
   output logic        rem_nonzero
);
   import mtq_pkg::*;

   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   // one shift-subtract step
   always_comb begin
      shifted = {rem_ff[31:0], quo_ff[47]};
      trial   = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = (rem_ff != '0);
endmodule

FILE: sv/mtq_datapath.sv
// module: clocks, timer table, event fifo and scan datapath
module mtq_datapath #(
   parameter int MAX_TIMERS  = mtq_pkg::MAX_TIMERS_DEF,
   parameter int EVENT_DEPTH = mtq_pkg::EVENT_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  mtq_pkg::ctl_type ctl,
   output mtq_pkg::sts_type sts,
   input  mtq_pkg::req_type req,
   input  logic [15:0]      time_scale,
   output mtq_pkg::rsp_type rsp_data
);
   import mtq_pkg::*;

   localparam int TW = $clog2(MAX_TIMERS + 1);
   localparam int TI = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int EW = $clog2(EVENT_DEPTH + 1);
   localparam int EI = $clog2(EVENT_DEPTH);

   // timer and event memories
   logic [31:0] period_mem [MAX_TIMERS];
   logic [7:0]  ident_mem  [MAX_TIMERS];
   logic [47:0] count_mem  [MAX_TIMERS];
   logic [7:0]  event_mem  [EVENT_DEPTH];

   req_type     req_ff;
   logic [47:0] real_ff;
   logic [55:0] virt_ff;
   logic [31:0] last_ff;
   logic [TW-1:0] used_ff;
   logic [EI-1:0] head_ff, tail_ff;
   logic [EW-1:0] fill_ff;
   logic [TW-1:0] idx_ff;
   logic [31:0] per_rd_ff;
   logic [7:0]  id_rd_ff;
   logic [47:0] cnt_rd_ff;
   logic        ev_valid_ff, rej_ff, drop_ff;
   logic [7:0]  ev_id_ff;
   logic [47:0] prod_ff;

   logic        div_done, rem_nz;
   logic [47:0] quo;
   logic        due;
   logic        push_ok;
   logic [TI-1:0] idx_sel;
   logic [TI-1:0] used_sel;

   assign idx_sel  = idx_ff[TI-1:0];
   assign used_sel = used_ff[TI-1:0];

   mtq_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (ctl.div_start),
      .dividend    (real_ff),
      .divisor     (per_rd_ff),
      .done        (div_done),
      .quotient    (quo),
      .rem_nonzero (rem_nz)
   );

   assign due     = (quo > cnt_rd_ff) || ((quo == cnt_rd_ff) && rem_nz);
   assign push_ok = (fill_ff < EW'(EVENT_DEPTH));

   // control state: clocks, counts, pointers, result flags
   always_ff @(posedge clock) begin
      if (reset) begin
         real_ff     <= '0;
         virt_ff     <= '0;
         last_ff     <= '0;
         used_ff     <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         idx_ff      <= '0;
         ev_valid_ff <= 1'b0;
         ev_id_ff    <= '0;
         rej_ff      <= 1'b0;
         drop_ff     <= 1'b0;
         prod_ff     <= '0;
      end else begin
         if (ctl.capture) begin
            ev_valid_ff <= 1'b0;
            ev_id_ff    <= '0;
            rej_ff      <= 1'b0;
            drop_ff     <= 1'b0;
            prod_ff     <= 48'(req.delta_us) * 48'(time_scale);
         end
         if (ctl.exec) begin
            case (req_ff.operation)
               OP_TICK: begin
                  last_ff <= req_ff.delta_us;
                  real_ff <= real_ff + 48'(req_ff.delta_us);
                  virt_ff <= virt_ff + 56'(prod_ff);
               end
               OP_ADD: begin
                  if (req_ff.timer_period == '0 || used_ff >= TW'(MAX_TIMERS)) begin
                     rej_ff <= 1'b1;
                  end else begin
                     used_ff <= used_ff + TW'(1);
                  end
               end
               OP_POLL: begin
                  if (fill_ff != '0) begin
                     ev_valid_ff <= 1'b1;
                     ev_id_ff    <= event_mem[head_ff];
                     head_ff     <= (head_ff == EI'(EVENT_DEPTH - 1)) ? '0 : head_ff + EI'(1);
                     fill_ff     <= fill_ff - EW'(1);
                  end
               end
               default: begin
                  used_ff <= '0;
               end
            endcase
         end
         if (ctl.scan_init) begin
            idx_ff <= '0;
         end
         if (ctl.update) begin
            idx_ff <= idx_ff + TW'(1);
            if (due) begin
               if (push_ok) begin
                  tail_ff <= (tail_ff == EI'(EVENT_DEPTH - 1)) ? '0 : tail_ff + EI'(1);
                  fill_ff <= fill_ff + EW'(1);
               end else begin
                  drop_ff <= 1'b1;
               end
            end
         end
      end
   end

   // request latch and table read registers
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req;
      end
      if (ctl.scan_rd) begin
         per_rd_ff <= period_mem[idx_sel];
         id_rd_ff  <= ident_mem[idx_sel];
         cnt_rd_ff <= count_mem[idx_sel];
      end
   end

   // table writes: add timer at fill slot, counter write back on firing
   always_ff @(posedge clock) begin
      if (ctl.exec && req_ff.operation == OP_ADD && req_ff.timer_period != '0
          && used_ff < TW'(MAX_TIMERS)) begin
         period_mem[used_sel] <= req_ff.timer_period;
         ident_mem[used_sel]  <= req_ff.timer_id;
         count_mem[used_sel]  <= '0;
      end else if (ctl.update && due) begin
         count_mem[idx_sel] <= (quo == CNT_MAX) ? CNT_MAX : quo + 48'd1;
      end
   end

   // event fifo write
   always_ff @(posedge clock) begin
      if (ctl.update && due && push_ok) begin
         event_mem[tail_ff] <= id_rd_ff;
      end
   end

   assign sts.is_tick   = (req_ff.operation == OP_TICK);
   assign sts.scan_more = (idx_ff < used_ff);
   assign sts.div_done  = div_done;

   assign rsp_data.event_valid    = ev_valid_ff;
   assign rsp_data.event_id       = ev_id_ff;
   assign rsp_data.real_time      = real_ff;
   assign rsp_data.virtual_time   = virt_ff[55:8];
   assign rsp_data.real_delta     = last_ff;
   assign rsp_data.timer_rejected = rej_ff;
   assign rsp_data.events_dropped = drop_ff;
endmodule

FILE: sv/mtq_ctrl.sv
// module: sequencing state machine for the timer event queue
module mtq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mtq_pkg::sts_type sts,
   output mtq_pkg::ctl_type ctl,
   output logic             busy,
   output logic             idle
);
   import mtq_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = 1'b1;
      idle     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            idle = !start;
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec      = 1'b1;
            ctl.scan_init = 1'b1;
            state_in      = sts.is_tick ? ST_SCAN_RD : ST_DONE;
         end
         ST_SCAN_RD: begin
            if (sts.scan_more) begin
               ctl.scan_rd = 1'b1;
               state_in    = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            ctl.div_start = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (sts.div_done) begin
               ctl.update = 1'b1;
               state_in   = ST_SCAN_RD;
            end
         end
         ST_DONE: begin
            ctl.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

FILE: sv/mtq_checker.sv
// checker: port-level properties of the timer event queue, bound to the top
module mtq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input mtq_pkg::rsp_type rsp_data,
   input logic             csr_ready
);
   import mtq_pkg::*;

   // an accepted request makes the block busy next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");

   // response strobe is a single cycle
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");

   // config not taken while busy
   a_csr: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready) else $error("config ready while busy");

   // event id is zero unless an event is reported
   a_evid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.event_valid |-> rsp_data.event_id == '0)
      else $error("event id without event");

   // a response never flags both a rejection and a drop
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.timer_rejected && rsp_data.events_dropped))
      else $error("conflicting flags");
endmodule

bind multi_timer_event_queue_core mtq_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
